// File: sv/edf_pkg.sv
package edf_pkg;

  // Input operations
  localparam logic [1:0] FUNC_TICK   = 2'd0;
  localparam logic [1:0] FUNC_ADD    = 2'd1;
  localparam logic [1:0] FUNC_REMOVE = 2'd2;
  localparam logic [1:0] FUNC_NONE   = 2'd3; // unused code, dropped

  // Slot status codes
  localparam logic [1:0] ST_PENDING   = 2'd0;
  localparam logic [1:0] ST_WAITING   = 2'd1;
  localparam logic [1:0] ST_RUNNING   = 2'd2;
  localparam logic [1:0] ST_COMPLETED = 2'd3;

  // Event kinds
  localparam logic [2:0] EV_INIT     = 3'd0;
  localparam logic [2:0] EV_MISSED   = 3'd1;
  localparam logic [2:0] EV_RESTART  = 3'd2;
  localparam logic [2:0] EV_COMPLETE = 3'd3;
  localparam logic [2:0] EV_PREEMPT  = 3'd4;
  localparam logic [2:0] EV_START    = 3'd5;

  typedef struct packed {
    logic [1:0]  func;
    logic [2:0]  task_id;
    logic [15:0] period;
    logic [15:0] duration;
    logic [15:0] start_delay;
  } in_item_t;

  typedef struct packed {
    logic [2:0] event_kind;
    logic [2:0] event_task;
    logic       last;
  } out_item_t;

  // Commands from the sequencer to one slot cell
  typedef struct packed {
    logic tick;     // per-slot tick processing step
    logic add;
    logic remove;
    logic inc_rt;   // runner gains runtime
    logic set_run;  // becomes runner
    logic set_wait; // preempted
  } cell_cmd_t;

  // Status from one slot cell
  typedef struct packed {
    logic       valid;
    logic [1:0] status;
    logic       ev_init;
    logic       ev_complete;
    logic       ev_missed;
    logic       ev_restart;
  } cell_sts_t;

endpackage

// File: sv/edf_cell.sv
// One task slot; also one stage of the selection chain that passes the
// best candidate so far toward the higher slots.
module edf_cell #(
  parameter int TW = 16,
  parameter int IW = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  edf_pkg::cell_cmd_t cmd_i,
  input  logic [TW-1:0]     period_i,
  input  logic [TW-1:0]     duration_i,
  input  logic [TW-1:0]     delay_i,
  input  logic              mode_i,
  input  logic [IW-1:0]     my_id_i,
  // chain from lower neighbor
  input  logic              c_found_i,
  input  logic [TW:0]       c_key_i,
  input  logic [IW-1:0]     c_id_i,
  output logic              c_found_o,
  output logic [TW:0]       c_key_o,
  output logic [IW-1:0]     c_id_o,
  output edf_pkg::cell_sts_t sts_o
);
  logic          valid_q, valid_d;
  logic [1:0]    status_q, status_d;
  logic [TW-1:0] per_q, dur_q, cnt_q, rt_q;
  logic [TW-1:0] per_d, dur_d, cnt_d, rt_d;
  logic [TW-1:0] cnt_dec;
  logic          ev_i, ev_c, ev_m, ev_r;
  logic [1:0]    st_mid;
  logic          cand;
  logic [TW:0]   key;

  // Tick and table updates
  always_comb begin
    valid_d = valid_q; status_d = status_q;
    per_d = per_q; dur_d = dur_q; cnt_d = cnt_q; rt_d = rt_q;
    ev_i = 1'b0; ev_c = 1'b0; ev_m = 1'b0; ev_r = 1'b0;
    cnt_dec = (cnt_q != '0) ? cnt_q - 1'b1 : cnt_q;
    st_mid = status_q;
    if (cmd_i.add && !valid_q) begin
      valid_d = 1'b1; status_d = edf_pkg::ST_PENDING;
      per_d = period_i; dur_d = duration_i; cnt_d = delay_i; rt_d = '0;
    end else if (cmd_i.remove && valid_q) begin
      valid_d = 1'b0; status_d = edf_pkg::ST_PENDING;
    end else if (cmd_i.inc_rt && valid_q) begin
      if (rt_q != '1) rt_d = rt_q + 1'b1;
    end else if (cmd_i.tick && valid_q) begin
      cnt_d = cnt_dec;
      if (status_q == edf_pkg::ST_PENDING) begin
        if (cnt_dec == '0) begin
          status_d = edf_pkg::ST_WAITING; cnt_d = per_q; ev_i = 1'b1;
        end
      end else begin
        if (status_q == edf_pkg::ST_RUNNING && rt_q >= dur_q) begin
          st_mid = edf_pkg::ST_COMPLETED; ev_c = 1'b1;
        end
        status_d = st_mid;
        if (cnt_dec == '0) begin
          if (st_mid != edf_pkg::ST_COMPLETED) ev_m = 1'b1;
          else ev_r = 1'b1;
          status_d = edf_pkg::ST_WAITING; rt_d = '0; cnt_d = per_q;
        end
      end
    end else if (cmd_i.set_run) begin
      status_d = edf_pkg::ST_RUNNING;
    end else if (cmd_i.set_wait) begin
      status_d = edf_pkg::ST_WAITING;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      status_q <= edf_pkg::ST_PENDING;
    end else begin
      valid_q  <= valid_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    per_q <= per_d; dur_q <= dur_d; cnt_q <= cnt_d; rt_q <= rt_d;
  end

  // Selection chain: zero countdown ranks last under EDF
  assign cand = valid_q && (status_q == edf_pkg::ST_WAITING ||
                            status_q == edf_pkg::ST_RUNNING);
  assign key  = mode_i ? {1'b0, per_q} :
                ((cnt_q != '0) ? {1'b0, cnt_q} : {1'b1, {TW{1'b0}}});
  always_comb begin
    c_found_o = c_found_i; c_key_o = c_key_i; c_id_o = c_id_i;
    if (cand && (!c_found_i || key < c_key_i)) begin
      c_found_o = 1'b1; c_key_o = key; c_id_o = my_id_i;
    end
  end

  assign sts_o = '{valid: valid_q, status: status_q, ev_init: ev_i,
                   ev_complete: ev_c, ev_missed: ev_m, ev_restart: ev_r};
endmodule

// File: sv/edf_rm_task_scheduler_unit.sv
// Task scheduler over MAX_TASKS slot cells. Each slot is a cell holding its
// period, duration, countdown, runtime and status; a combinational chain
// through the cells picks the runner (least deadline or least period, ties
// to the lower slot). An item is handled by a sequencer: a tick first
// credits runtime to the runner, then processes each slot in slot order
// (events from a slot are queued before the next slot is processed), then
// selects and issues up to two preempt/start events. An event is staged
// until its last flag is known and then waits for the output ready.
// The mode register is taken only while no item is in flight.
module edf_rm_task_scheduler_unit #(
  parameter int MAX_TASKS  = 8,
  parameter int TIME_WIDTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  edf_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output edf_pkg::out_item_t  out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_data_i
);
  localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int TW = TIME_WIDTH;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_RT   = 7'b0000010, S_SLOT = 7'b0000100,
    S_EVQ  = 7'b0001000, S_SEL  = 7'b0010000, S_PRE  = 7'b0100000,
    S_STRT = 7'b1000000
  } state_e;

  state_e               st_q, st_d;
  edf_pkg::in_item_t    it_q;
  logic                 mode_q;
  logic                 rp_q, rp_d;
  logic [IW-1:0]        rs_q, rs_d;
  logic [IW-1:0]        idx_q, idx_d;
  logic [3:0]           evs_q, evs_d;   // pending init/complete/missed/restart
  logic                 have_q, have_d; // unsent event latched
  edf_pkg::out_item_t   ob_q, ob_d;
  logic                 ov_q, ov_d;
  logic                 pend_q, pend_d; // event waiting for the last flag

  edf_pkg::cell_cmd_t   cmd [MAX_TASKS];
  edf_pkg::cell_sts_t   sts [MAX_TASKS];
  logic                 cf [MAX_TASKS+1];
  logic [TW:0]          ck [MAX_TASKS+1];
  logic [IW-1:0]        ci [MAX_TASKS+1];

  assign cf[0] = 1'b0;
  assign ck[0] = '0;
  assign ci[0] = '0;

  logic tid_ok;
  assign tid_ok = ({29'd0, it_q.task_id} < 32'(MAX_TASKS));

  genvar g;
  generate
    for (g = 0; g < MAX_TASKS; g++) begin : g_cell
      edf_cell #(.TW(TW), .IW(IW)) u_cell (
        .clk_i, .rst_ni, .cmd_i(cmd[g]),
        .period_i(TW'(it_q.period)), .duration_i(TW'(it_q.duration)),
        .delay_i(TW'(it_q.start_delay)), .mode_i(mode_q),
        .my_id_i(IW'(g)),
        .c_found_i(cf[g]), .c_key_i(ck[g]), .c_id_i(ci[g]),
        .c_found_o(cf[g+1]), .c_key_o(ck[g+1]), .c_id_o(ci[g+1]),
        .sts_o(sts[g])
      );
    end
  endgenerate

  assign in_ready_o  = (st_q == S_IDLE) && !ov_q && !pend_q;
  assign cfg_ready_o = (st_q == S_IDLE) && !ov_q && !pend_q;
  assign out_valid_o = ov_q;
  assign out_data_o  = ob_q;

  // Output side: a staged event is released when the next one arrives or
  // when the item ends, so the last flag is known.
  logic       push, fin, can_push;
  logic [2:0] push_kind, push_task;
  assign can_push = !ov_q || out_ready_i;

  always_comb begin
    st_d = st_q; rp_d = rp_q; rs_d = rs_q; idx_d = idx_q;
    evs_d = evs_q;
    push = 1'b0; fin = 1'b0; push_kind = '0; push_task = '0;
    for (int i = 0; i < MAX_TASKS; i++) cmd[i] = '0;
    case (st_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          if (in_data_i.func == edf_pkg::FUNC_TICK) st_d = S_RT;
          else if (in_data_i.func == edf_pkg::FUNC_NONE) st_d = S_IDLE;
          else st_d = S_SLOT;
          idx_d = '0;
        end
      end
      S_RT: begin
        if (rp_q) cmd[rs_q].inc_rt = 1'b1;
        st_d = S_SLOT;
      end
      S_SLOT: begin
        if (it_q.func == edf_pkg::FUNC_TICK) begin
          cmd[idx_q].tick = 1'b1;
          evs_d = {sts[idx_q].ev_init, sts[idx_q].ev_complete,
                   sts[idx_q].ev_missed, sts[idx_q].ev_restart};
          if (sts[idx_q].ev_complete) rp_d = 1'b0;
          if (sts[idx_q].ev_missed && sts[idx_q].status == edf_pkg::ST_RUNNING
              && !sts[idx_q].ev_complete) rp_d = 1'b0;
          st_d = S_EVQ;
        end else begin
          if (tid_ok) begin
            if (it_q.func == edf_pkg::FUNC_ADD) cmd[IW'(it_q.task_id)].add = 1'b1;
            else begin
              cmd[IW'(it_q.task_id)].remove = 1'b1;
              if (sts[IW'(it_q.task_id)].valid && rp_q &&
                  rs_q == IW'(it_q.task_id)) rp_d = 1'b0;
            end
          end
          st_d = S_SEL;
        end
      end
      S_EVQ: begin
        // order: init, complete, then missed or restart
        if (evs_q != '0) begin
          if (can_push || !have_q) begin
            push = 1'b1; push_task = 3'(idx_q);
            if (evs_q[3]) begin
              push_kind = edf_pkg::EV_INIT; evs_d[3] = 1'b0;
            end else if (evs_q[2]) begin
              push_kind = edf_pkg::EV_COMPLETE; evs_d[2] = 1'b0;
            end else if (evs_q[1]) begin
              push_kind = edf_pkg::EV_MISSED; evs_d[1] = 1'b0;
            end else begin
              push_kind = edf_pkg::EV_RESTART; evs_d[0] = 1'b0;
            end
          end
        end else if (32'(idx_q) == MAX_TASKS - 1) begin
          st_d = S_SEL;
        end else begin
          idx_d = idx_q + 1'b1; st_d = S_SLOT;
        end
      end
      S_SEL: begin
        if (!cf[MAX_TASKS]) begin
          rp_d = 1'b0; st_d = S_IDLE; fin = 1'b1;
        end else if (rp_q && rs_q == ci[MAX_TASKS]) begin
          st_d = S_IDLE; fin = 1'b1;
        end else begin
          idx_d = ci[MAX_TASKS];
          st_d = rp_q ? S_PRE : S_STRT;
        end
      end
      S_PRE: begin
        if (can_push || !have_q) begin
          cmd[rs_q].set_wait = 1'b1;
          push = 1'b1; push_kind = edf_pkg::EV_PREEMPT; push_task = 3'(rs_q);
          st_d = S_STRT;
        end
      end
      S_STRT: begin
        if (can_push || !have_q) begin
          cmd[idx_q].set_run = 1'b1;
          push = 1'b1; push_kind = edf_pkg::EV_START; push_task = 3'(idx_q);
          rp_d = 1'b1; rs_d = idx_q;
          st_d = S_IDLE; fin = 1'b1;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  // Staging register holds one event until its last flag is known
  edf_pkg::out_item_t stg_q, stg_d;
  always_comb begin
    ob_d = ob_q; ov_d = ov_q && !out_ready_i;
    stg_d = stg_q; pend_d = pend_q;
    if (push) begin
      if (pend_q) begin
        ob_d = stg_q; ov_d = 1'b1;
      end
      stg_d = '{event_kind: push_kind, event_task: push_task, last: 1'b0};
      pend_d = 1'b1;
    end
    if (fin) begin
      if (push) begin
        // both handed out at once is impossible; start is final after flush
        stg_d.last = 1'b1;
      end else if (pend_q && can_push) begin
        ob_d = stg_q; ob_d.last = 1'b1; ov_d = 1'b1; pend_d = 1'b0;
      end
    end
    if (!push && !fin && pend_q && stg_q.last && can_push) begin
      ob_d = stg_q; ov_d = 1'b1; pend_d = 1'b0;
    end
  end
  assign have_d = pend_d;

  // fin in S_SEL while staging is blocked: hold until it drains
  logic fin_block;
  assign fin_block = fin && !push && pend_q && !can_push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; mode_q <= 1'b0; rp_q <= 1'b0; rs_q <= '0;
      idx_q <= '0; evs_q <= '0; have_q <= 1'b0; ov_q <= 1'b0; pend_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) mode_q <= cfg_data_i;
      st_q <= fin_block ? st_q : st_d;
      rp_q <= rp_d; rs_q <= rs_d; idx_q <= idx_d; evs_q <= evs_d;
      have_q <= have_d; ov_q <= ov_d; pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ob_q <= ob_d; stg_q <= stg_d;
    if (in_valid_i && in_ready_o) it_q <= in_data_i;
  end

  // Checks
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |-> !out_valid_o)
    else $error("item accepted with output busy");
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(st_q)) else $error("state not one-hot");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(out_data_o))
    else $error("output changed while stalled");
endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int NSLOT = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 40;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  edf_pkg::in_item_t in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  edf_pkg::out_item_t out_data_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic cfg_data_i;

  edf_rm_task_scheduler_unit #(
    .MAX_TASKS (NSLOT),
    .TIME_WIDTH(16)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  // Scheduler shadow state
  bit        sh_valid [NSLOT];
  bit [1:0]  sh_status[NSLOT];
  bit [15:0] sh_period[NSLOT];
  bit [15:0] sh_dur   [NSLOT];
  bit [15:0] sh_count [NSLOT];
  bit [15:0] sh_rt    [NSLOT];
  bit        sh_run_on;
  bit [2:0]  sh_run_id;
  bit        sh_rm_mode;

  edf_pkg::out_item_t event_q[$];
  int        err_count;
  int        cycle_count;
  bit        calm;
  bit        hold_req;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic report(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic void push_event(input logic [2:0] kind, input logic [2:0] slot);
    edf_pkg::out_item_t ev;
    ev.event_kind = kind;
    ev.event_task = slot;
    ev.last = 1'b0;
    event_q.push_back(ev);
  endfunction

  // Runner choice: least deadline (zero ranks last) or least period
  function automatic void pick_runner();
    bit found;
    bit [2:0] best;
    logic [16:0] best_key;
    logic [16:0] key;
    found = 0;
    best = 0;
    best_key = 0;
    for (int i = 0; i < NSLOT; i++) begin
      if (!sh_valid[i]) continue;
      if (sh_status[i] != edf_pkg::ST_WAITING && sh_status[i] != edf_pkg::ST_RUNNING)
        continue;
      if (sh_rm_mode) key = {1'b0, sh_period[i]};
      else key = (sh_count[i] != 0) ? {1'b0, sh_count[i]} : 17'h10000;
      if (!found || key < best_key) begin
        found = 1;
        best = 3'(i);
        best_key = key;
      end
    end
    if (!found) begin
      sh_run_on = 0;
      return;
    end
    if (sh_run_on && sh_run_id == best) return;
    if (sh_run_on) begin
      sh_status[sh_run_id] = edf_pkg::ST_WAITING;
      push_event(edf_pkg::EV_PREEMPT, sh_run_id);
    end
    sh_run_on = 1;
    sh_run_id = best;
    sh_status[best] = edf_pkg::ST_RUNNING;
    push_event(edf_pkg::EV_START, best);
  endfunction

  function automatic void advance_time();
    if (sh_run_on && sh_valid[sh_run_id] && sh_rt[sh_run_id] != 16'hFFFF)
      sh_rt[sh_run_id]++;
    for (int i = 0; i < NSLOT; i++) begin
      if (!sh_valid[i]) continue;
      if (sh_count[i] != 0) sh_count[i]--;
      if (sh_status[i] == edf_pkg::ST_PENDING) begin
        if (sh_count[i] == 0) begin
          sh_status[i] = edf_pkg::ST_WAITING;
          sh_count[i] = sh_period[i];
          push_event(edf_pkg::EV_INIT, 3'(i));
        end
        continue;
      end
      if (sh_status[i] == edf_pkg::ST_RUNNING && sh_rt[i] >= sh_dur[i]) begin
        sh_status[i] = edf_pkg::ST_COMPLETED;
        sh_run_on = 0;
        push_event(edf_pkg::EV_COMPLETE, 3'(i));
      end
      if (sh_count[i] == 0) begin
        if (sh_status[i] != edf_pkg::ST_COMPLETED) begin
          if (sh_status[i] == edf_pkg::ST_RUNNING) sh_run_on = 0;
          push_event(edf_pkg::EV_MISSED, 3'(i));
        end else begin
          push_event(edf_pkg::EV_RESTART, 3'(i));
        end
        sh_status[i] = edf_pkg::ST_WAITING;
        sh_rt[i] = 0;
        sh_count[i] = sh_period[i];
      end
    end
  endfunction

  // Expected events for one accepted item
  function automatic void predict_events(input edf_pkg::in_item_t it);
    int n_prior;
    n_prior = event_q.size();
    if (it.func == edf_pkg::FUNC_NONE) return;
    if (it.func == edf_pkg::FUNC_TICK) begin
      advance_time();
    end else if (it.func == edf_pkg::FUNC_ADD) begin
      if (!sh_valid[it.task_id]) begin
        sh_valid[it.task_id] = 1;
        sh_status[it.task_id] = edf_pkg::ST_PENDING;
        sh_period[it.task_id] = it.period;
        sh_dur[it.task_id] = it.duration;
        sh_count[it.task_id] = it.start_delay;
        sh_rt[it.task_id] = 0;
      end
    end else if (sh_valid[it.task_id]) begin
      sh_valid[it.task_id] = 0;
      sh_status[it.task_id] = edf_pkg::ST_PENDING;
      if (sh_run_on && sh_run_id == it.task_id) sh_run_on = 0;
    end
    pick_runner();
    if (event_q.size() > n_prior) event_q[event_q.size() - 1].last = 1'b1;
  endfunction

  // Send one item, with random gaps unless in a calm stretch
  task automatic send_item(input edf_pkg::in_item_t it);
    if (!calm && $urandom_range(99) < 29) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_events(it);
  endtask

  task automatic send_op(input logic [1:0] f, input logic [2:0] id,
                         input logic [15:0] per, input logic [15:0] dur,
                         input logic [15:0] dly);
    edf_pkg::in_item_t it;
    it.func = f;
    it.task_id = id;
    it.period = per;
    it.duration = dur;
    it.start_delay = dly;
    send_item(it);
  endtask

  // Lower valid, let every expected event arrive, then let the block settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (event_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_mode(input bit rm);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= rm;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    sh_rm_mode = rm;
  endtask

  // Mostly short periodic tasks and ticks, some noise and extreme values
  function automatic edf_pkg::in_item_t rand_item();
    edf_pkg::in_item_t it;
    int r;
    r = $urandom_range(99);
    it.task_id = 3'($urandom_range(NSLOT - 1));
    it.period = 16'($urandom_range(1, 12));
    it.duration = 16'($urandom_range(0, 6));
    it.start_delay = 16'($urandom_range(0, 4));
    if (r < 62) it.func = edf_pkg::FUNC_TICK;
    else if (r < 84) it.func = edf_pkg::FUNC_ADD;
    else if (r < 96) it.func = edf_pkg::FUNC_REMOVE;
    else it.func = edf_pkg::FUNC_NONE;
    if ($urandom_range(99) < 6) begin
      it.period = 16'($urandom);
      it.duration = 16'($urandom);
      it.start_delay = $urandom_range(0, 1) ? 16'($urandom) : 16'd0;
    end
    return it;
  endfunction

  task automatic test_random(input int n);
    repeat (n) send_item(rand_item());
    drain();
  endtask

  task automatic test_directed();
    send_op(edf_pkg::FUNC_ADD, 3'd0, 16'd3, 16'd1, 16'd0);
    send_op(edf_pkg::FUNC_ADD, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_op(edf_pkg::FUNC_ADD, 3'd0, 16'd9, 16'd9, 16'd9);   // slot in use
    send_op(edf_pkg::FUNC_REMOVE, 3'd5, 16'd0, 16'd0, 16'd0); // empty slot
    send_op(edf_pkg::FUNC_NONE, 3'd2, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    repeat (4) send_op(edf_pkg::FUNC_TICK, 3'd0, 16'd0, 16'd0, 16'd0);
    send_op(edf_pkg::FUNC_ADD, 3'd2, 16'd0, 16'd0, 16'd1);    // zero period, zero duration
    send_op(edf_pkg::FUNC_ADD, 3'd4, 16'd2, 16'd5, 16'd0);
    repeat (5) send_op(edf_pkg::FUNC_TICK, 3'd0, 16'd0, 16'd0, 16'd0);
    send_op(edf_pkg::FUNC_REMOVE, sh_run_id, 16'd0, 16'd0, 16'd0); // drop the runner
    send_op(edf_pkg::FUNC_TICK, 3'd0, 16'd0, 16'd0, 16'd0);
    send_op(edf_pkg::FUNC_REMOVE, 3'd2, 16'd0, 16'd0, 16'd0);
    send_op(edf_pkg::FUNC_REMOVE, 3'd7, 16'd0, 16'd0, 16'd0);
    drain();
  endtask

  // Receiver stalls while ticks keep coming, so the block backs up
  task automatic test_hold_off();
    for (int i = 0; i < NSLOT; i++)
      send_op(edf_pkg::FUNC_ADD, 3'(i), 16'($urandom_range(1, 4)),
              16'($urandom_range(0, 2)), 16'd0);
    hold_req = 1;
    repeat (30) send_op(edf_pkg::FUNC_TICK, 3'd0, 16'd0, 16'd0, 16'd0);
    drain();
  endtask

  task automatic test_calm(input int n);
    calm = 1;
    test_random(n);
    calm = 0;
  endtask

  // Long receiver hold-off, counted here
  initial begin
    forever begin
      wait (hold_req);
      repeat (HOLD_CYCLES) @(posedge clk_i);
      hold_req = 0;
    end
  end

  // Result check and output-side stalls
  always @(posedge clk_i) begin
    edf_pkg::out_item_t exp_ev;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (event_q.size() == 0) begin
        report($sformatf("unexpected event kind %0d task %0d",
                         out_data_o.event_kind, out_data_o.event_task));
      end else begin
        exp_ev = event_q.pop_front();
        if (out_data_o.event_kind !== exp_ev.event_kind)
          report($sformatf("event_kind %0d, expected %0d",
                           out_data_o.event_kind, exp_ev.event_kind));
        if (out_data_o.event_task !== exp_ev.event_task)
          report($sformatf("event_task %0d, expected %0d",
                           out_data_o.event_task, exp_ev.event_task));
        if (out_data_o.last !== exp_ev.last)
          report($sformatf("last %0d, expected %0d", out_data_o.last, exp_ev.last));
      end
    end
    if (hold_req) out_ready_i <= 1'b0;
    else if (calm) out_ready_i <= 1'b1;
    else out_ready_i <= ($urandom_range(99) >= 29);
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = 1'b0;
    err_count = 0;
    cycle_count = 0;
    calm = 0;
    hold_req = 0;
    sh_run_on = 0;
    sh_run_id = 0;
    sh_rm_mode = 0;
    for (int i = 0; i < NSLOT; i++) begin
      sh_valid[i] = 0;
      sh_status[i] = edf_pkg::ST_PENDING;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    set_mode(1'b1);
    test_random(110);
    set_mode(1'b0);
    test_hold_off();
    test_calm(90);
    set_mode(1'b1);
    test_random(80);
    set_mode(1'b0);
    test_random(100);

    drain();
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/edf_pkg.sv
sv/edf_cell.sv
sv/edf_rm_task_scheduler_unit.sv
dv/testbench.sv
